[rtl/fpr_pkg.sv]
// ============================================================================
// FIFO page replacement package
// Shared widths, constants and reset values for the page replacement block.
// ============================================================================
package fpr_pkg;

	// Fixed field widths of the request and result channels and the frame count register.
	localparam int PAGE_W  = 16;
	localparam int FRAME_W = 4;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 5;

	// Default sizing of the frame set.
	localparam int FPR_MAX_FRAMES = 16;
	localparam int FPR_PAGE_BITS  = 16;

	// Frame count register value after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	// Saturation value of the hit and miss totals.
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

[rtl/fpr_if.sv]
// ============================================================================
// FIFO page replacement channels
// Valid/ready interfaces for page requests and lookup results.
// ============================================================================

// Page request channel.
interface fpr_page_if import fpr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

// Lookup result channel.
interface fpr_result_if import fpr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [FRAME_W-1:0] frame_used;
	logic [CNT_W-1:0]   hit_total;
	logic [CNT_W-1:0]   miss_total;

	modport source (output valid, output hit, output frame_used, output hit_total,
		output miss_total, input ready);
	modport sink   (input valid, input hit, input frame_used, input hit_total,
		input miss_total, output ready);
endinterface

[rtl/fpr_cell.sv]
// ============================================================================
// FIFO page replacement frame cell
// Holds one page frame, compares it against the broadcast page and passes
// the first-match indication on to the next cell in the chain.
// ============================================================================
module fpr_cell import fpr_pkg::*; #(
	parameter int PAGE_BITS = FPR_PAGE_BITS,
	parameter int IDX_W     = 4,
	parameter int CELL_IDX  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 active,
	input  logic [PAGE_BITS-1:0] key,
	input  logic                 fill_en,
	input  logic [IDX_W-1:0]     fill_slot,
	input  logic                 found_in,
	input  logic [IDX_W-1:0]     idx_in,
	output logic                 found_out,
	output logic [IDX_W-1:0]     idx_out
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 match;
	logic                 load;

	// An empty or unused frame never matches.
	assign match = active & valid_q & (page_q == key);
	assign load  = fill_en & (fill_slot == IDX_W'(CELL_IDX));

	// The lowest matching frame wins: a match earlier in the chain is kept.
	assign found_out = found_in | match;
	assign idx_out   = found_in ? idx_in : IDX_W'(CELL_IDX);

	// Valid mark, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	// Page contents, only read behind the valid mark.
	always_ff @(posedge clk) begin
		if (load) begin
			page_q <= key;
		end
	end

endmodule

[rtl/fifo_page_replacement.sv]
// Result: registered, presented in the cycle after its request is accepted.
// Throughput: one request per cycle while the result register is free or drains;
// the frame lookup is a single pass down the cell chain and the fill pointer updates in the same cycle.
// Reset: all frames are empty, the fill pointer and both totals are zero,
// and the frame count register reads 16. No clearing pass is needed.
// ============================================================================
// FIFO page replacement
// Fully associative frame set with round-robin fill and saturating totals.
// ============================================================================
module fifo_page_replacement import fpr_pkg::*; #(
	parameter int MAX_FRAMES = FPR_MAX_FRAMES,
	parameter int PAGE_BITS  = FPR_PAGE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	fpr_page_if.sink          page_ch,
	fpr_result_if.source      result_ch,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int N_W   = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W = (N_W > CFG_W) ? N_W : CFG_W;

	logic [CFG_W-1:0]     frames_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     hit_cnt_q;
	logic [CNT_W-1:0]     miss_cnt_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   frame_q;

	logic [CMP_W-1:0]     cfg_ext;
	logic [N_W-1:0]       n_eff;
	logic [PAGE_BITS-1:0] key;
	logic                 accept;
	logic                 miss_wr;
	logic [IDX_W-1:0]     fill_slot;
	logic [IDX_W-1:0]     ptr_next;
	logic [IDX_W-1:0]     slot;
	logic                 found_chain [0:MAX_FRAMES];
	logic [IDX_W-1:0]     idx_chain   [0:MAX_FRAMES];

	// Handshake: a new request enters while the result register is free or drains.
	assign page_ch.ready = ~out_valid_q | result_ch.ready;
	assign accept        = page_ch.valid & page_ch.ready;

	// Only the low PAGE_BITS of the page take part in the lookup.
	assign key = PAGE_BITS'(page_ch.page);

	// Effective frame count: zero acts as one, larger values clip at the maximum.
	assign cfg_ext = CMP_W'(frames_q);
	always_comb begin
		if (cfg_ext == '0) begin
			n_eff = N_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
			n_eff = N_W'(MAX_FRAMES);
		end else begin
			n_eff = N_W'(cfg_ext);
		end
	end

	// Fill slot and pointer advance; a stale pointer beyond the count restarts at zero.
	always_comb begin
		if (N_W'(ptr_q) >= n_eff) begin
			fill_slot = '0;
		end else begin
			fill_slot = ptr_q;
		end
		if (N_W'(fill_slot) + N_W'(1) >= n_eff) begin
			ptr_next = '0;
		end else begin
			ptr_next = fill_slot + IDX_W'(1);
		end
	end

	// Chain of frame cells, searched from frame zero upward.
	assign found_chain[0] = 1'b0;
	assign idx_chain[0]   = '0;
	assign miss_wr        = accept & ~found_chain[MAX_FRAMES];

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		fpr_cell #(
			.PAGE_BITS (PAGE_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.active    (N_W'(i) < n_eff),
			.key       (key),
			.fill_en   (miss_wr),
			.fill_slot (fill_slot),
			.found_in  (found_chain[i]),
			.idx_in    (idx_chain[i]),
			.found_out (found_chain[i+1]),
			.idx_out   (idx_chain[i+1])
		);
	end

	assign slot = found_chain[MAX_FRAMES] ? idx_chain[MAX_FRAMES] : fill_slot;

	// Frame count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	// Fill pointer and saturating totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (accept) begin
			if (found_chain[MAX_FRAMES]) begin
				if (hit_cnt_q != CNT_MAX) begin
					hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end
			end else begin
				ptr_q <= ptr_next;
				if (miss_cnt_q != CNT_MAX) begin
					miss_cnt_q <= miss_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q   <= found_chain[MAX_FRAMES];
			frame_q <= FRAME_W'(slot);
		end
	end

	// The totals registers hold steady while a result waits, so they drive it directly.
	assign result_ch.valid      = out_valid_q;
	assign result_ch.hit        = hit_q;
	assign result_ch.frame_used = frame_q;
	assign result_ch.hit_total  = hit_cnt_q;
	assign result_ch.miss_total = miss_cnt_q;

endmodule

[tb/fifo_page_replacement_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// FIFO page replacement testbench
// Sends page requests through the block and checks every lookup result
// against a predictor that tracks frames, fill pointer and totals. A short
// scripted sequence covers empty frames, frame count limits and multiple
// matches. Randomized phases follow, each with its own frame count and page
// pool, and with random idle gaps on both channels.
// ============================================================================
module fifo_page_replacement_test import fpr_pkg::*; ();

	localparam int SCRIPT_LEN     = 28;
	localparam int RAND_PHASES    = 10;
	localparam int PHASE_ITEMS    = 50;
	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

	// One scripted step: a page request, or a write of the frame count.
	typedef struct packed {
		row_kind_e          kind;
		logic [PAGE_W-1:0]  value;
		logic               pinned;
		logic               hit;
		logic [FRAME_W-1:0] frame;
	} script_row_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame_used;
		logic [CNT_W-1:0]   hit_total;
		logic [CNT_W-1:0]   miss_total;
	} lookup_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	fpr_page_if   page_ch ();
	fpr_result_if result_ch ();

	fifo_page_replacement dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.page_ch  (page_ch),
		.result_ch(result_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the frame set and the frame count register.
	logic [PAGE_W-1:0] frame_pages [FPR_MAX_FRAMES];
	bit                frame_loaded [FPR_MAX_FRAMES];
	int unsigned       fill_slot;
	logic [CNT_W-1:0]  hits_seen;
	logic [CNT_W-1:0]  misses_seen;
	logic [CFG_W-1:0]  frames_cfg;

	lookup_t pending_lookups [$];
	int      mismatch_count;
	int      idle_cycles;

	// Values typed into the script for the request now on offer.
	bit                 pin_on;
	logic               pin_hit;
	logic [FRAME_W-1:0] pin_frame;

	bit send_steady;
	bit recv_steady;
	bit hold_results;

	// Frame count 0 behaves as 1, and counts above the frame set saturate.
	script_row_t script [SCRIPT_LEN] = '{
		'{ROW_REQ, 16'h0000, 1'b1, 1'b0, 4'd0},
		'{ROW_REQ, 16'h0000, 1'b1, 1'b1, 4'd0},
		'{ROW_REQ, 16'hFFFF, 1'b1, 1'b0, 4'd1},
		'{ROW_REQ, 16'hFFFF, 1'b1, 1'b1, 4'd1},
		'{ROW_REQ, 16'h8000, 1'b1, 1'b0, 4'd2},
		'{ROW_REQ, 16'h0001, 1'b1, 1'b0, 4'd3},
		'{ROW_CFG, 16'd1,    1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'h1234, 1'b1, 1'b0, 4'd0},
		'{ROW_REQ, 16'hFFFF, 1'b1, 1'b0, 4'd0},
		'{ROW_REQ, 16'hFFFF, 1'b1, 1'b1, 4'd0},
		'{ROW_CFG, 16'd17,   1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'hFFFF, 1'b1, 1'b1, 4'd0},
		'{ROW_CFG, 16'd0,    1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'hAAAA, 1'b1, 1'b0, 4'd0},
		'{ROW_REQ, 16'hAAAA, 1'b1, 1'b1, 4'd0},
		'{ROW_CFG, 16'd31,   1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'hFFFF, 1'b1, 1'b1, 4'd1},
		'{ROW_REQ, 16'h8000, 1'b1, 1'b1, 4'd2},
		'{ROW_REQ, 16'h5555, 1'b1, 1'b0, 4'd0},
		'{ROW_REQ, 16'h5555, 1'b1, 1'b1, 4'd0},
		'{ROW_REQ, 16'h1234, 1'b0, 1'b0, 4'd0},
		'{ROW_CFG, 16'd2,    1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'h7E81, 1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'h0181, 1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'h7E81, 1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'h5555, 1'b0, 1'b0, 4'd0},
		'{ROW_CFG, 16'd16,   1'b0, 1'b0, 4'd0},
		'{ROW_REQ, 16'h0001, 1'b0, 1'b0, 4'd0}
	};

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Look a page up in the predicted frame set and update it.
	function automatic lookup_t predict_lookup(input logic [PAGE_W-1:0] value);
		lookup_t     res;
		int unsigned span;
		int unsigned slot;
		bit          found;
		span = 32'(frames_cfg);
		if (span == 0)
			span = 1;
		if (span > FPR_MAX_FRAMES)
			span = FPR_MAX_FRAMES;
		found = 1'b0;
		slot = 0;
		for (int i = 0; i < span; i++) begin
			if (!found && frame_loaded[i] && frame_pages[i] == value) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (found) begin
			if (hits_seen != CNT_MAX)
				hits_seen++;
		end else begin
			slot = (fill_slot >= span) ? 0 : fill_slot;
			frame_pages[slot] = value;
			frame_loaded[slot] = 1'b1;
			fill_slot = (slot + 1 >= span) ? 0 : slot + 1;
			if (misses_seen != CNT_MAX)
				misses_seen++;
		end
		res.hit = found;
		res.frame_used = FRAME_W'(slot);
		res.hit_total = hits_seen;
		res.miss_total = misses_seen;
		return res;
	endfunction

	function automatic int draw_gap(input bit steady);
		return steady ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic report_mismatch(input string field, input logic [CNT_W-1:0] got,
		input logic [CNT_W-1:0] want);
		$display("ERROR at %0t: %s is %0h, expected %0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// Stop offering requests and wait until every lookup has returned.
	task automatic wait_all_results();
		@(negedge clk);
		page_ch.valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
	endtask

	// The frame count is only written while no request is in flight.
	task automatic write_frame_count(input logic [CFG_W-1:0] value);
		wait_all_results();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		frames_cfg = value;
	endtask

	// Offer one request after a random gap and return once it is taken.
	task automatic offer_page(input logic [PAGE_W-1:0] value, input bit pin,
		input logic pin_h, input logic [FRAME_W-1:0] pin_f);
		int gap;
		gap = draw_gap(send_steady);
		repeat (gap) begin
			@(negedge clk);
			page_ch.valid <= 1'b0;
		end
		@(negedge clk);
		page_ch.valid <= 1'b1;
		page_ch.page <= value;
		pin_on = pin;
		pin_hit = pin_h;
		pin_frame = pin_f;
		do
			@(posedge clk);
		while (!page_ch.ready);
	endtask

	// Predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_lookups.size() == 0) begin
					report_mismatch("unrequested result, miss_total", result_ch.miss_total, '0);
				end else begin
					want = pending_lookups.pop_front();
					if (result_ch.hit !== want.hit)
						report_mismatch("hit", CNT_W'(result_ch.hit), CNT_W'(want.hit));
					if (result_ch.frame_used !== want.frame_used)
						report_mismatch("frame_used", CNT_W'(result_ch.frame_used),
							CNT_W'(want.frame_used));
					if (result_ch.hit_total !== want.hit_total)
						report_mismatch("hit_total", result_ch.hit_total, want.hit_total);
					if (result_ch.miss_total !== want.miss_total)
						report_mismatch("miss_total", result_ch.miss_total, want.miss_total);
				end
			end
			if (page_ch.valid && page_ch.ready) begin
				want = predict_lookup(page_ch.page);
				if (pin_on) begin
					want.hit = pin_hit;
					want.frame_used = pin_frame;
				end
				pending_lookups.push_back(want);
			end
			// Watchdog on cycles where neither channel moves a request.
			if ((page_ch.valid && page_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** fifo_page_replacement: FAILED **");
				$finish;
			end
		end
	end

	// Result receiver with random stalls and a single long hold-off.
	initial begin : result_receiver
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					result_ch.ready <= 1'b0;
				end
			end
			stall = draw_gap(recv_steady);
			repeat (stall) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_ch.valid);
		end
	end

	// Reset, scripted sequence, randomized phases, then the verdict.
	initial begin : stimulus
		logic [CFG_W-1:0]  phase_cfg [6];
		logic [PAGE_W-1:0] pool [24];
		logic [PAGE_W-1:0] next_page;
		int pool_n;
		int pick;

		phase_cfg = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd17, 5'd2};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		page_ch.valid = 1'b0;
		page_ch.page = '0;
		pin_on = 1'b0;
		pin_hit = 1'b0;
		pin_frame = '0;
		send_steady = 1'b0;
		recv_steady = 1'b0;
		hold_results = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		foreach (frame_pages[i]) begin
			frame_pages[i] = '0;
			frame_loaded[i] = 1'b0;
		end
		fill_slot = 0;
		hits_seen = '0;
		misses_seen = '0;
		frames_cfg = CFG_RESET;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Scripted sequence.
		foreach (script[r]) begin
			if (script[r].kind == ROW_CFG)
				write_frame_count(script[r].value[CFG_W-1:0]);
			else
				offer_page(script[r].value, script[r].pinned, script[r].hit, script[r].frame);
		end

		// Random phases, each with its own frame count and page pool.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase < 6)
				write_frame_count(phase_cfg[phase]);
			else
				write_frame_count(CFG_W'($urandom_range(0, 31)));
			pool_n = $urandom_range(2, 24);
			for (int i = 0; i < pool_n; i++)
				pool[i] = ($urandom_range(0, 9) == 0) ? '0 : PAGE_W'($urandom());
			send_steady = ($urandom_range(0, 3) == 0);
			recv_steady = ($urandom_range(0, 3) == 0);
			if (phase == 2)
				hold_results = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ((phase == 4 && i == PHASE_ITEMS / 2) || $urandom_range(0, 59) == 0)
					wait_all_results();
				pick = $urandom_range(0, 99);
				if (pick < 75)
					next_page = pool[$urandom_range(0, pool_n - 1)];
				else if (pick < 80)
					next_page = pick[0] ? '1 : '0;
				else
					next_page = PAGE_W'($urandom());
				offer_page(next_page, 1'b0, 1'b0, '0);
			end
		end

		wait_all_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("** fifo_page_replacement: PASSED **");
		else
			$display("** fifo_page_replacement: FAILED **");
		$finish;
	end

endmodule
